// ----- hdl/npc_pkg.sv -----
// Shared types and constants for the nearest palette color search.
package npc_pkg;

   localparam int INDEX_BITS = 8;
   localparam int FIVE_BITS = 5;
   localparam int RED_LSB = 10;
   localparam int GREEN_LSB = 5;
   localparam int BLUE_LSB = 0;
   localparam int TRANSPARENT_INDEX = 255;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_QUERY_COMP = 2'd1;
   localparam logic [1:0] KIND_QUERY_PACKED = 2'd2;

   typedef struct packed {
      logic                  valid;
      logic [INDEX_BITS-1:0] index;
   } npc_tag_type;

endpackage

// ----- hdl/npc_palette_ram.sv -----
// Palette memory with one write port and one registered read port.
module npc_palette_ram #(
   parameter int DEPTH = 256,
   parameter int DATA_BITS = 18
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hdl/npc_dist_unit.sv -----
// Shared distance unit: squared component differences, registered, then summed.
module npc_dist_unit
   import npc_pkg::*;
#(
   parameter int COMPONENT_BITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  npc_tag_type                   in_tag,
   input  logic [3*COMPONENT_BITS-1:0]   entry,
   input  logic [COMPONENT_BITS-1:0]     query_red,
   input  logic [COMPONENT_BITS-1:0]     query_green,
   input  logic [COMPONENT_BITS-1:0]     query_blue,
   output npc_tag_type                   out_tag,
   output logic [2*COMPONENT_BITS+1:0]   distance
);

   localparam int CB = COMPONENT_BITS;
   localparam int SB = 2 * CB;
   localparam int DW = SB + 2;

   logic [CB-1:0] ent_red;
   logic [CB-1:0] ent_green;
   logic [CB-1:0] ent_blue;
   logic [CB-1:0] diff_red;
   logic [CB-1:0] diff_green;
   logic [CB-1:0] diff_blue;
   logic [SB-1:0] sq_red_in;
   logic [SB-1:0] sq_green_in;
   logic [SB-1:0] sq_blue_in;
   logic [SB-1:0] sq_red_ff;
   logic [SB-1:0] sq_green_ff;
   logic [SB-1:0] sq_blue_ff;
   npc_tag_type   tag_ff;

   assign ent_red = entry[2*CB +: CB];
   assign ent_green = entry[CB +: CB];
   assign ent_blue = entry[0 +: CB];

   always_comb begin
      diff_red = (query_red > ent_red) ? (query_red - ent_red) : (ent_red - query_red);
      diff_green = (query_green > ent_green) ? (query_green - ent_green)
                                             : (ent_green - query_green);
      diff_blue = (query_blue > ent_blue) ? (query_blue - ent_blue) : (ent_blue - query_blue);
      sq_red_in = SB'(diff_red) * SB'(diff_red);
      sq_green_in = SB'(diff_green) * SB'(diff_green);
      sq_blue_in = SB'(diff_blue) * SB'(diff_blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= in_tag;
      end
      sq_red_ff <= sq_red_in;
      sq_green_ff <= sq_green_in;
      sq_blue_ff <= sq_blue_in;
   end

   assign out_tag = tag_ff;
   assign distance = DW'(sq_red_ff) + DW'(sq_green_ff) + DW'(sq_blue_ff);

endmodule

// ----- hdl/nearest_palette_color.sv -----
// Top level of the nearest palette color search: sequencer, query registers, best tracking.
//
// A request is taken when start is high and busy is low. Kind zero loads one
// palette entry in that cycle and gives no response; busy stays low. Kind one
// queries with the red, green and blue components; kind two queries with a
// packed 5-5-5 word whose fields are doubled. Kind three is ignored.
// A query raises busy and walks the palette one entry per cycle through the
// palette memory read port and the shared distance unit, which form a
// pipeline of the registered read and the registered squares. A full walk
// covers entries 0 to 254; an exact match stops the walk early. The last
// palette entry (index 255 for a full palette) is never returned.
// The response shows on rsp_nearest_index for one cycle with rsp_valid high,
// and busy falls in that same cycle; the receiver cannot stall the block.
// Reset clears the sequencer but not the palette, whose entries must be
// loaded before they are searched.
module nearest_palette_color
   import npc_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256,
   parameter int COMPONENT_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_kind,
   input  logic [INDEX_BITS-1:0] req_entry_index,
   input  logic [5:0]            req_red,
   input  logic [5:0]            req_green,
   input  logic [5:0]            req_blue,
   input  logic [14:0]           req_packed_rgb,
   output logic                  rsp_valid,
   output logic [INDEX_BITS-1:0] rsp_nearest_index
);

   localparam int CB = COMPONENT_BITS;
   localparam int DW = 2 * CB + 2;
   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam int SCAN_LIMIT = (PALETTE_DEPTH < TRANSPARENT_INDEX + 1)
                               ? PALETTE_DEPTH - 1 : TRANSPARENT_INDEX;
   localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(SCAN_LIMIT - 1);

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   state_type             state_ff;
   logic [INDEX_BITS-1:0] issue_idx_ff;
   logic                  issue_done_ff;
   npc_tag_type           rd_tag_ff;
   npc_tag_type           rd_tag_in;
   logic [CB-1:0]         q_red_ff;
   logic [CB-1:0]         q_green_ff;
   logic [CB-1:0]         q_blue_ff;
   logic [DW-1:0]         best_dist_ff;
   logic [INDEX_BITS-1:0] best_idx_ff;
   logic                  rsp_valid_ff;
   logic [INDEX_BITS-1:0] rsp_index_ff;

   logic                  req_accept;
   logic                  load_en;
   logic                  query_start;
   logic [CB-1:0]         in_red;
   logic [CB-1:0]         in_green;
   logic [CB-1:0]         in_blue;
   logic [3*CB-1:0]       rd_data;
   npc_tag_type           dist_in_tag;
   npc_tag_type           dist_tag;
   logic [DW-1:0]         dist_sum;
   logic                  cmp_valid;
   logic                  hit_zero;
   logic                  better;
   logic                  finish;
   logic                  issue_fire;
   logic [INDEX_BITS-1:0] final_idx;

   assign busy = (state_ff != ST_IDLE);
   assign req_accept = start && !busy;
   assign load_en = req_accept && (req_kind == KIND_LOAD)
                    && (int'(req_entry_index) < PALETTE_DEPTH);
   assign query_start = req_accept && (req_kind inside {KIND_QUERY_COMP, KIND_QUERY_PACKED});

   always_comb begin
      if (req_kind == KIND_QUERY_PACKED) begin
         in_red = CB'({req_packed_rgb[RED_LSB +: FIVE_BITS], 1'b0});
         in_green = CB'({req_packed_rgb[GREEN_LSB +: FIVE_BITS], 1'b0});
         in_blue = CB'({req_packed_rgb[BLUE_LSB +: FIVE_BITS], 1'b0});
      end else begin
         in_red = CB'(req_red);
         in_green = CB'(req_green);
         in_blue = CB'(req_blue);
      end
   end

   npc_palette_ram #(
      .DEPTH     (PALETTE_DEPTH),
      .DATA_BITS (3 * CB)
   ) u_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({CB'(req_red), CB'(req_green), CB'(req_blue)}),
      .rd_addr (AW'(issue_idx_ff)),
      .rd_data (rd_data)
   );

   npc_dist_unit #(
      .COMPONENT_BITS (CB)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_tag      (dist_in_tag),
      .entry       (rd_data),
      .query_red   (q_red_ff),
      .query_green (q_green_ff),
      .query_blue  (q_blue_ff),
      .out_tag     (dist_tag),
      .distance    (dist_sum)
   );

   always_comb begin
      cmp_valid = dist_tag.valid && (state_ff == ST_SEARCH);
      hit_zero = (dist_sum == '0);
      better = (dist_tag.index == '0) || (dist_sum < best_dist_ff);
      finish = cmp_valid && (hit_zero || (dist_tag.index == LAST_INDEX));
      final_idx = (hit_zero || better) ? dist_tag.index : best_idx_ff;
      issue_fire = (state_ff == ST_SEARCH) && !issue_done_ff && !finish;
      rd_tag_in.valid = issue_fire;
      rd_tag_in.index = issue_idx_ff;
      dist_in_tag.valid = rd_tag_ff.valid && !finish;
      dist_in_tag.index = rd_tag_ff.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_done_ff <= 1'b0;
         rd_tag_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_tag_ff <= rd_tag_in;
         rsp_valid_ff <= finish;
         case (state_ff)
            ST_IDLE: begin
               if (query_start) begin
                  state_ff <= ST_SEARCH;
                  issue_done_ff <= 1'b0;
               end
            end
            ST_SEARCH: begin
               if (finish) begin
                  state_ff <= ST_IDLE;
               end else if (issue_fire && (issue_idx_ff == LAST_INDEX)) begin
                  issue_done_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (query_start) begin
         issue_idx_ff <= '0;
         q_red_ff <= in_red;
         q_green_ff <= in_green;
         q_blue_ff <= in_blue;
      end else if (issue_fire) begin
         issue_idx_ff <= issue_idx_ff + 1'b1;
      end
      if (cmp_valid && better) begin
         best_dist_ff <= dist_sum;
         best_idx_ff <= dist_tag.index;
      end
      if (finish) begin
         rsp_index_ff <= final_idx;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;

endmodule
